// ----- rtl/byte_ring_deque_macros.svh -----
// Assertion helpers shared by the RTL files of the byte ring deque.
// Every assertion is clocked on clk and is off while rst_n is low.
`ifndef BYTE_RING_DEQUE_MACROS_SVH
`define BYTE_RING_DEQUE_MACROS_SVH

// Checks that a property holds at every rising edge of clk.
`define BRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that a condition never holds.
`define BRD_NEVER(lbl, cond, msg) \
  `BRD_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/brd_pkg.sv -----
// ----------------------------------------------------------------------------
// brd_pkg
// Types and fixed widths for the byte ring deque: the word formats of the
// input and result channels, operation codes, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned OCC_W = 13;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP        = 2'd2,
    OP_PEEK       = 2'd3
  } op_t;

  typedef struct packed {
    op_t              opcode;
    logic [7:0]       data_in;
    logic [CNT_W-1:0] count;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       data_out;
    logic             byte_valid;
    logic             accepted;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic push_back;   // store at tail
    logic push_front;  // store just before head
    logic push_res;    // emit the result of a push, stored or refused
    logic empty_res;   // emit the result of a read that returns nothing
    logic burst_start; // load the read pointer from head
    logic rd_issue;    // read one byte and emit it
    logic rd_pop;      // the byte read is removed
    logic rd_last;     // the byte read is the final one of its word
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic             full;
    logic             slot_free; // the result pipeline takes a word this cycle
    logic [CNT_W-1:0] avail;     // bytes held, capped at the burst limit
  } sts_t;

endpackage

// ----- rtl/brd_ctrl.sv -----
// ----------------------------------------------------------------------------
// brd_ctrl
// Controller of the byte ring deque. Decodes each input word, sizes a read
// burst and steps through it one byte per free result slot.
// ----------------------------------------------------------------------------
`include "byte_ring_deque_macros.svh"

module brd_ctrl #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  brd_pkg::in_word_t in_data,
  input  brd_pkg::sts_t     sts,
  output brd_pkg::cmd_t     cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  localparam logic [brd_pkg::CNT_W-1:0] BURST_MAX = brd_pkg::CNT_W'(MAX_BURST);

  state_t                    state_r, state_nxt;
  logic [brd_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic                      pop_r, pop_nxt;

  logic                      accept;
  logic                      is_push;
  logic [brd_pkg::CNT_W-1:0] want;
  logic [brd_pkg::CNT_W-1:0] nbytes;

  always_comb begin
    in_ready = (state_r == ST_IDLE) && sts.slot_free;
    accept   = in_valid && in_ready;
    is_push  = (in_data.opcode == brd_pkg::OP_PUSH_BACK) ||
               (in_data.opcode == brd_pkg::OP_PUSH_FRONT);

    if (in_data.count > BURST_MAX) begin
      want = BURST_MAX;
    end else begin
      want = in_data.count;
    end
    nbytes = (want < sts.avail) ? want : sts.avail;

    cmd.push_back   = accept && (in_data.opcode == brd_pkg::OP_PUSH_BACK) && !sts.full;
    cmd.push_front  = accept && (in_data.opcode == brd_pkg::OP_PUSH_FRONT) && !sts.full;
    cmd.push_res    = accept && is_push;
    cmd.empty_res   = accept && !is_push && (nbytes == '0);
    cmd.burst_start = accept && !is_push && (nbytes != '0);
    cmd.rd_issue    = (state_r == ST_BURST) && sts.slot_free;
    cmd.rd_pop      = pop_r;
    cmd.rd_last     = (rem_r == brd_pkg::CNT_W'(1));
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    pop_nxt   = pop_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.burst_start) begin
          state_nxt = ST_BURST;
          rem_nxt   = nbytes;
          pop_nxt   = (in_data.opcode == brd_pkg::OP_POP);
        end
      end
      ST_BURST: begin
        if (cmd.rd_issue) begin
          rem_nxt = rem_r - 1'b1;
          if (cmd.rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rem_r   <= '0;
      pop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      pop_r   <= pop_nxt;
    end
  end

  `BRD_ASSERT(a_burst_blocks_input, (state_r == ST_BURST) |-> !in_ready, "input taken during a burst")
  `BRD_NEVER(a_burst_has_bytes, (state_r == ST_BURST) && (rem_r == '0), "burst with no bytes left")

endmodule

// ----- rtl/brd_datapath.sv -----
// ----------------------------------------------------------------------------
// brd_datapath
// Datapath of the byte ring deque: the byte memory, head, tail and fill
// registers, the read pointer of a burst, and a two-word result pipeline
// (memory read stage, then the output register).
// ----------------------------------------------------------------------------
`include "byte_ring_deque_macros.svh"

module brd_datapath #(
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  brd_pkg::cmd_t      cmd,
  input  logic [7:0]         push_byte,
  output brd_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output brd_pkg::out_word_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > brd_pkg::CNT_W) ? FW : brd_pkg::CNT_W;

  logic [7:0] mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] rdp_r, rdp_nxt;
  logic [7:0]    rd_data_r;

  // Read stage.
  logic                      a_valid_r;
  logic                      a_rd_r;
  logic                      a_acc_r;
  logic                      a_last_r;
  logic [brd_pkg::OCC_W-1:0] a_occ_r;

  // Output register.
  logic               out_valid_r;
  brd_pkg::out_word_t out_r;

  logic          adv;
  logic          slot_free;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] rdp_inc;

  always_comb begin
    adv       = !out_valid_r || out_ready;
    slot_free = !a_valid_r || adv;
    head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
    tail_inc  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    rdp_inc   = (rdp_r == AW'(DEPTH - 1)) ? '0 : rdp_r + 1'b1;

    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    rdp_nxt  = rdp_r;
    if (cmd.push_back) begin
      tail_nxt = tail_inc;
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.push_front) begin
      head_nxt = head_dec;
      fill_nxt = fill_r + 1'b1;
    end
    if (cmd.burst_start) begin
      rdp_nxt = head_r;
    end
    if (cmd.rd_issue) begin
      rdp_nxt = rdp_inc;
      if (cmd.rd_pop) begin
        head_nxt = rdp_inc;
        fill_nxt = fill_r - 1'b1;
      end
    end

    sts.full      = (fill_r == FW'(DEPTH));
    sts.slot_free = slot_free;
    if (CW'(fill_r) >= CW'(MAX_BURST)) begin
      sts.avail = brd_pkg::CNT_W'(MAX_BURST);
    end else begin
      sts.avail = brd_pkg::CNT_W'(fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_back) begin
      mem[tail_r] <= push_byte;
    end else if (cmd.push_front) begin
      mem[head_dec] <= push_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rdp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      rdp_r       <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
      rdp_r  <= rdp_nxt;
      if (slot_free) begin
        a_valid_r <= cmd.push_res || cmd.empty_res || cmd.rd_issue;
      end
      if (adv) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  // Payload of the two result stages.
  always_ff @(posedge clk) begin
    if (slot_free) begin
      a_rd_r   <= cmd.rd_issue;
      a_acc_r  <= cmd.push_back || cmd.push_front;
      a_last_r <= cmd.rd_issue ? cmd.rd_last : 1'b1;
      a_occ_r  <= brd_pkg::OCC_W'(fill_nxt);
    end
    if (adv) begin
      out_r.data_out   <= a_rd_r ? rd_data_r : 8'd0;
      out_r.byte_valid <= a_rd_r;
      out_r.accepted   <= a_acc_r;
      out_r.last       <= a_last_r;
      out_r.occupancy  <= a_occ_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BRD_ASSERT(a_empty_ptrs, (fill_r == '0) |-> (head_r == tail_r), "empty with head and tail apart")
  `BRD_ASSERT(a_full_ptrs, (fill_r == FW'(DEPTH)) |-> (head_r == tail_r), "full with head and tail apart")
  `BRD_NEVER(a_fill_range, fill_r > FW'(DEPTH), "fill count above depth")
  `BRD_ASSERT(a_read_slot, cmd.rd_issue |-> slot_free, "read issued with no free result slot")

endmodule

// ----- rtl/byte_ring_deque.sv -----
// ----------------------------------------------------------------------------
// byte_ring_deque
// Circular byte deque with push at either end, pop and peek of short bursts.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one word per
//   operation. A push gives one result word with accepted set when stored.
//   A pop or peek gives one result word per byte returned, up to count
//   (capped at MAX_BURST) and no more than the bytes held; last marks the
//   final one. A read that returns nothing gives one word with byte_valid 0.
//   Results leave on (out_valid, out_ready, out_data) through an output
//   register, so the next word is taken while a result waits.
//   A result word passes the read stage and then the output register; a
//   read first starts its burst and then reads its bytes. A read holds
//   the input until its last byte is issued, one byte per cycle from the
//   single read port of the byte memory while a result slot is free.
//   Reset clears head, tail and fill count; the memory is not cleared and
//   no clearing pass runs. When the receiver stalls, the result pipeline
//   fills two words deep and then in_ready falls until it drains.
// ----------------------------------------------------------------------------
module byte_ring_deque #(
  parameter int unsigned DEPTH     = 4096,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  brd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output brd_pkg::out_word_t out_data
);

  brd_pkg::cmd_t cmd;
  brd_pkg::sts_t sts;

  brd_ctrl #(
    .MAX_BURST(MAX_BURST)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  brd_datapath #(
    .DEPTH    (DEPTH),
    .MAX_BURST(MAX_BURST)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .push_byte (in_data.data_in),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb_byte_ring_deque.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_deque
// Self-checking bench for the byte ring deque. A clocked driver feeds
// operation words from a queue, a mirror of the ring predicts every result
// word, and a clocked monitor compares each result field by field. Stimulus
// runs a short directed set, random mixes of push bursts and reads under
// changing idle rates and a long receiver hold-off, and a final drain past
// empty.
// ----------------------------------------------------------------------------
module tb_byte_ring_deque;

  localparam int unsigned RING_DEPTH     = 4096;
  localparam int unsigned BURST_MAX      = 64;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  brd_pkg::in_word_t   in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  brd_pkg::out_word_t  out_data;

  byte_ring_deque #(
    .DEPTH    (RING_DEPTH),
    .MAX_BURST(BURST_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the ring, advanced once per accepted operation word.
  logic [7:0]  ring_mem [RING_DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  int unsigned ring_fill = 0;

  brd_pkg::in_word_t  op_queue[$];
  brd_pkg::out_word_t due_words[$];
  brd_pkg::out_word_t got_word;
  int unsigned n_queued     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_errors     = 0;
  int unsigned send_idle    = 0;
  int unsigned recv_idle    = 0;
  int unsigned rx_hold_left = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_ack     = 0;

  function automatic void deque_op_results(brd_pkg::in_word_t w);
    brd_pkg::out_word_t r;
    int unsigned        n;
    int unsigned        pos;
    r = '0;
    if (w.opcode == brd_pkg::OP_PUSH_BACK || w.opcode == brd_pkg::OP_PUSH_FRONT) begin
      if (ring_fill < RING_DEPTH) begin
        if (w.opcode == brd_pkg::OP_PUSH_BACK) begin
          ring_mem[ring_tail] = w.data_in;
          ring_tail = (ring_tail + 1) % RING_DEPTH;
        end else begin
          ring_head = (ring_head == 0) ? RING_DEPTH - 1 : ring_head - 1;
          ring_mem[ring_head] = w.data_in;
        end
        ring_fill++;
        r.accepted = 1'b1;
      end
      r.last      = 1'b1;
      r.occupancy = brd_pkg::OCC_W'(ring_fill);
      due_words.push_back(r);
    end else begin
      n = (w.count > BURST_MAX) ? BURST_MAX : w.count;
      if (n > ring_fill) n = ring_fill;
      if (n == 0) begin
        r.last      = 1'b1;
        r.occupancy = brd_pkg::OCC_W'(ring_fill);
        due_words.push_back(r);
      end
      pos = ring_head;
      for (int unsigned i = 0; i < n; i++) begin
        r.data_out = ring_mem[pos];
        pos = (pos + 1) % RING_DEPTH;
        if (w.opcode == brd_pkg::OP_POP) begin
          ring_head = pos;
          ring_fill--;
        end
        r.byte_valid = 1'b1;
        r.last       = (i + 1 == n);
        r.occupancy  = brd_pkg::OCC_W'(ring_fill);
        due_words.push_back(r);
      end
    end
  endfunction

  function automatic void queue_op(brd_pkg::op_t op, logic [7:0] d,
                                   logic [brd_pkg::CNT_W-1:0] c);
    brd_pkg::in_word_t w;
    w.opcode  = op;
    w.data_in = d;
    w.count   = c;
    op_queue.push_back(w);
    n_queued++;
  endfunction

  // Push bursts, reads of mostly legal counts, and some fully random words.
  function automatic void queue_random_ops(int unsigned n_items);
    int unsigned               done_cnt;
    int unsigned               burst;
    int unsigned               sel;
    logic [brd_pkg::CNT_W-1:0] cnt;
    done_cnt = 0;
    while (done_cnt < n_items) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        burst = $urandom_range(1, 12);
        for (int unsigned k = 0; k < burst; k++)
          queue_op($urandom_range(1) ? brd_pkg::OP_PUSH_FRONT : brd_pkg::OP_PUSH_BACK,
                   8'($urandom), brd_pkg::CNT_W'($urandom));
        done_cnt += burst;
      end else if (sel < 88) begin
        sel = $urandom_range(9);
        cnt = (sel == 0) ? '0 :
              (sel == 1) ? brd_pkg::CNT_W'($urandom_range(65, 127)) :
                           brd_pkg::CNT_W'($urandom_range(1, BURST_MAX));
        queue_op(($urandom_range(99) < 60) ? brd_pkg::OP_POP : brd_pkg::OP_PEEK,
                 8'($urandom), cnt);
        done_cnt++;
      end else begin
        queue_op(brd_pkg::op_t'($urandom_range(3)), 8'($urandom),
                 brd_pkg::CNT_W'($urandom));
        done_cnt++;
      end
    end
  endfunction

  task automatic wait_drained();
    while (n_accepted != n_queued || due_words.size() != 0) @(negedge clk);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Driver: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deque_op_results(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          in_data  <= op_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest one due.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          $error("result word %h arrived with none due", out_data);
          n_errors++;
        end else begin
          got_word = due_words.pop_front();
          check_field("data_out", got_word.data_out, out_data.data_out);
          check_field("byte_valid", got_word.byte_valid, out_data.byte_valid);
          check_field("accepted", got_word.accepted, out_data.accepted);
          check_field("last", got_word.last, out_data.last);
          check_field("occupancy", got_word.occupancy, out_data.occupancy);
        end
      end
      out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Receiver hold-off, counted here once the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack     <= hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 38;
    recv_idle = 55;
    // Reads on an empty ring, head wrap on the first push front, zero and
    // oversized counts, then a partial drain.
    queue_op(brd_pkg::OP_POP, 8'h00, 7'd1);
    queue_op(brd_pkg::OP_PEEK, 8'hff, 7'd64);
    queue_op(brd_pkg::OP_PUSH_FRONT, 8'hff, 7'd1);
    queue_op(brd_pkg::OP_PUSH_BACK, 8'h00, 7'd0);
    queue_op(brd_pkg::OP_PUSH_BACK, 8'ha5, 7'd127);
    queue_op(brd_pkg::OP_PUSH_FRONT, 8'h5a, 7'd64);
    queue_op(brd_pkg::OP_PEEK, 8'h00, 7'd0);
    queue_op(brd_pkg::OP_POP, 8'h00, 7'd0);
    queue_op(brd_pkg::OP_PEEK, 8'h00, 7'd127);
    queue_op(brd_pkg::OP_POP, 8'h00, 7'd2);
    queue_op(brd_pkg::OP_PEEK, 8'h00, 7'd64);
    queue_op(brd_pkg::OP_POP, 8'h00, 7'd65);
    queue_op(brd_pkg::OP_POP, 8'hff, 7'd1);
    queue_op(brd_pkg::OP_PEEK, 8'hff, 7'd127);
    queue_random_ops(90);

    // Long receiver hold-off while the sender keeps offering words, so the
    // result pipeline fills and the input stalls.
    wait_drained();
    for (int i = 0; i < 30; i++) queue_op(brd_pkg::OP_PUSH_BACK, 8'($urandom), 7'd1);
    for (int i = 0; i < 4; i++) queue_op(brd_pkg::OP_PEEK, 8'h00, 7'd64);
    queue_op(brd_pkg::OP_POP, 8'h00, 7'd20);
    queue_op(brd_pkg::OP_POP, 8'h00, 7'd20);
    hold_req++;
    wait_drained();
    queue_random_ops(10);
    wait_drained();

    send_idle = 55;
    recv_idle = 38;
    queue_random_ops(100);
    wait_drained();

    // No idling on either side, then drain past empty.
    send_idle = 0;
    recv_idle = 0;
    queue_random_ops(20);
    wait_drained();
    for (int unsigned i = 0; i <= ring_fill / BURST_MAX; i++)
      queue_op(brd_pkg::OP_POP, 8'h00, 7'd64);
    queue_op(brd_pkg::OP_PEEK, 8'h00, 7'd1);
    wait_drained();

    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("byte_ring_deque regression: pass");
    end else begin
      $display("byte_ring_deque regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("byte_ring_deque regression: fail");
    $finish;
  end

endmodule
